/* rtl/aet_pkg.sv */
// ----------------------------------------------------------------------------
// aet_pkg
// Shared types and constants for the arithmetic expression tokenizer.
// ----------------------------------------------------------------------------
package aet_pkg;

  localparam int MANTISSA_BITS_DEF = 48;
  localparam int POSITION_BITS_DEF = 16;
  localparam int QUEUE_DEPTH_DEF   = 2;

  // fixed field widths of the result word
  localparam int MANT_OUT_BITS = 48;
  localparam int POS_OUT_BITS  = 16;
  localparam int FRAC_BITS     = 4;
  localparam int CHAR_BITS     = 8;
  localparam int KIND_BITS     = 3;
  localparam int OUT_DATA_BITS = 80;
  localparam int IN_DATA_BITS  = 8;

  localparam logic [FRAC_BITS-1:0] FRAC_MAX = 4'd15;

  typedef enum logic [KIND_BITS-1:0] {
    TK_NUMBER   = 3'd0,
    TK_LPAREN   = 3'd1,
    TK_RPAREN   = 3'd2,
    TK_OPERATOR = 3'd3,
    TK_BAD      = 3'd4,
    TK_END      = 3'd5
  } tok_kind_t;

  localparam logic [CHAR_BITS-1:0] CH_NUL    = 8'h00;
  localparam logic [CHAR_BITS-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_BITS-1:0] CH_LPAREN = 8'h28;
  localparam logic [CHAR_BITS-1:0] CH_RPAREN = 8'h29;
  localparam logic [CHAR_BITS-1:0] CH_STAR   = 8'h2A;
  localparam logic [CHAR_BITS-1:0] CH_PLUS   = 8'h2B;
  localparam logic [CHAR_BITS-1:0] CH_MINUS  = 8'h2D;
  localparam logic [CHAR_BITS-1:0] CH_DOT    = 8'h2E;
  localparam logic [CHAR_BITS-1:0] CH_SLASH  = 8'h2F;
  localparam logic [CHAR_BITS-1:0] CH_ZERO   = 8'h30;
  localparam logic [CHAR_BITS-1:0] CH_NINE   = 8'h39;

  // One queue entry: an optional number token followed by the symbol token
  typedef struct packed {
    logic                     has_num;
    logic [MANT_OUT_BITS-1:0] mant;
    logic [FRAC_BITS-1:0]     frac;
    logic                     ovf;
    tok_kind_t                kind;
    logic [CHAR_BITS-1:0]     symbol;
    logic [POS_OUT_BITS-1:0]  pos;
  } tok_entry_t;

endpackage

/* rtl/aet_front.sv */
// ----------------------------------------------------------------------------
// aet_front
// Classifies each character, gathers numbers and pushes token entries.
// ----------------------------------------------------------------------------
module aet_front import aet_pkg::*; #(
  parameter int MANTISSA_BITS = MANTISSA_BITS_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [CHAR_BITS-1:0] char_code,
  output logic                 push,
  output tok_entry_t           entry
);

  logic [MANTISSA_BITS-1:0] mant;
  logic [FRAC_BITS-1:0]     frac;
  logic                     digits;
  logic                     point;
  logic                     ovf;
  logic [POSITION_BITS-1:0] char_pos;

  logic                       is_space;
  logic                       is_dot;
  logic                       is_digit;
  logic [CHAR_BITS-1:0]       diff;
  logic [3:0]                 digit;
  logic [MANTISSA_BITS+3:0]   prod;
  logic                       fits;
  logic [MANTISSA_BITS+MANT_OUT_BITS-1:0] mant_ext;
  logic [POSITION_BITS+POS_OUT_BITS-1:0]  pos_ext;
  tok_kind_t                  kind;

  always_comb begin
    is_space = (char_code == CH_SPACE);
    is_dot   = (char_code == CH_DOT);
    is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    diff     = char_code - CH_ZERO;
    digit    = diff[3:0];
    // m*10 + d with four bits of headroom; fits when the top nibble is clear
    prod     = ({4'd0, mant} << 3) + ({4'd0, mant} << 1)
               + {{MANTISSA_BITS{1'b0}}, digit};
    fits     = (prod[MANTISSA_BITS+3:MANTISSA_BITS] == 4'd0);
    mant_ext = {{MANT_OUT_BITS{1'b0}}, mant};
    pos_ext  = {{POS_OUT_BITS{1'b0}}, char_pos};
    case (char_code)
      CH_NUL:    kind = TK_END;
      CH_LPAREN: kind = TK_LPAREN;
      CH_RPAREN: kind = TK_RPAREN;
      CH_STAR:   kind = TK_OPERATOR;
      CH_SLASH:  kind = TK_OPERATOR;
      CH_PLUS:   kind = TK_OPERATOR;
      CH_MINUS:  kind = TK_OPERATOR;
      default:   kind = TK_BAD;
    endcase
  end

  assign push = accept && !is_space && !is_dot && !is_digit;

  always_comb begin
    entry.has_num = digits;
    entry.mant    = mant_ext[MANT_OUT_BITS-1:0];
    entry.frac    = frac;
    entry.ovf     = ovf;
    entry.kind    = kind;
    entry.symbol  = char_code;
    entry.pos     = pos_ext[POS_OUT_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mant     <= '0;
      frac     <= '0;
      digits   <= 1'b0;
      point    <= 1'b0;
      ovf      <= 1'b0;
      char_pos <= '0;
    end else if (accept) begin
      char_pos <= char_pos + 1'b1;
      if (is_dot) begin
        point <= 1'b1;
      end else if (is_digit) begin
        digits <= 1'b1;
        if (!point) begin
          if (fits) begin
            mant <= prod[MANTISSA_BITS-1:0];
          end else begin
            mant <= '1;
            ovf  <= 1'b1;
          end
        end else if (fits && (frac != FRAC_MAX)) begin
          mant <= prod[MANTISSA_BITS-1:0];
          frac <= frac + 1'b1;
        end else begin
          ovf <= 1'b1;  // fractional digit dropped
        end
      end else if (!is_space) begin
        // a dot with no digits stays pending until a number or end of text
        if (digits || (kind == TK_END)) begin
          mant   <= '0;
          frac   <= '0;
          digits <= 1'b0;
          point  <= 1'b0;
          ovf    <= 1'b0;
        end
        if (kind == TK_END) begin
          char_pos <= '0;
        end
      end
    end
  end

endmodule

/* rtl/aet_queue.sv */
// ----------------------------------------------------------------------------
// aet_queue
// Short register queue of token entries between front and back.
// ----------------------------------------------------------------------------
module aet_queue import aet_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  tok_entry_t wr_entry,
  input  logic       pop,
  output tok_entry_t head,
  output logic       not_empty,
  output logic       full
);

  localparam int PTR_BITS = $clog2(DEPTH);
  localparam int CNT_BITS = $clog2(DEPTH + 1);
  localparam logic [PTR_BITS-1:0] LAST_SLOT = PTR_BITS'(DEPTH - 1);
  localparam logic [CNT_BITS-1:0] FULL_CNT  = CNT_BITS'(DEPTH);

  tok_entry_t            slots [DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr;
  logic [PTR_BITS-1:0]   rd_ptr;
  logic [CNT_BITS-1:0]   count;
  logic                  do_push;
  logic                  do_pop;

  assign not_empty = (count != '0);
  assign full      = (count == FULL_CNT);
  assign head      = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/aet_back.sv */
// ----------------------------------------------------------------------------
// aet_back
// Drains queue entries onto the result stream, one or two words each.
// ----------------------------------------------------------------------------
module aet_back import aet_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  tok_entry_t               head,
  input  logic                     head_valid,
  output logic                     pop,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [OUT_DATA_BITS-1:0] out_data,
  output logic [KIND_BITS-1:0]     out_user,
  output logic                     out_last
);

  logic       phase;  // number word of this entry already sent
  logic       show_num;
  logic       xfer;
  tok_kind_t  kind;
  logic [MANT_OUT_BITS-1:0] mant;
  logic [FRAC_BITS-1:0]     frac;
  logic                     ovf;
  logic [CHAR_BITS-1:0]     symbol;

  assign show_num  = head.has_num && !phase;
  assign out_valid = head_valid;
  assign xfer      = head_valid && out_ready;
  assign pop       = xfer && !show_num;
  assign out_last  = !show_num;

  always_comb begin
    if (show_num) begin
      kind   = TK_NUMBER;
      mant   = head.mant;
      frac   = head.frac;
      ovf    = head.ovf;
      symbol = CH_SPACE;
    end else begin
      kind   = head.kind;
      mant   = '0;
      frac   = '0;
      ovf    = 1'b0;
      symbol = head.symbol;
    end
    out_user = kind;
    out_data = {3'd0, head.pos, symbol, ovf, frac, mant};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 1'b0;
    end else if (xfer) begin
      phase <= show_num;
    end
  end

endmodule

/* rtl/arithmetic_expression_tokenizer.sv */
// Path: a character accepted on s_axis that gives a result is registered in the token queue before m_axis shows it.
// Throughput: one character per cycle while s_axis_tready is high; spaces, digits
// and dots give no result, a character that closes a number gives two words.
// The token queue (QUEUE_DEPTH entries) absorbs output stalls before s_axis_tready drops.
// Reset: synchronous; number state and position go to zero and the queue empties.
// ----------------------------------------------------------------------------
// arithmetic_expression_tokenizer
// Character stream lexer giving number, paren, operator, bad-character and
// end tokens.
// ----------------------------------------------------------------------------
module arithmetic_expression_tokenizer import aet_pkg::*; #(
  parameter int MANTISSA_BITS = MANTISSA_BITS_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF,
  parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,   // [7:0] char_code
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // [47:0] mantissa, [51:48] fraction_digits, [52] overflow,
  // [60:53] symbol, [76:61] position, [79:77] zero
  output logic [OUT_DATA_BITS-1:0] m_axis_tdata,
  output logic [KIND_BITS-1:0]     m_axis_tuser,   // [2:0] token_kind
  output logic                     m_axis_tlast
);

  logic       accept;
  logic       push;
  logic       pop;
  logic       full;
  logic       not_empty;
  tok_entry_t wr_entry;
  tok_entry_t head;

  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && !full;

  aet_front #(
    .MANTISSA_BITS(MANTISSA_BITS),
    .POSITION_BITS(POSITION_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .char_code(s_axis_tdata[CHAR_BITS-1:0]),
    .push     (push),
    .entry    (wr_entry)
  );

  aet_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .pop      (pop),
    .head     (head),
    .not_empty(not_empty),
    .full     (full)
  );

  aet_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .head_valid(not_empty),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_user  (m_axis_tuser),
    .out_last  (m_axis_tlast)
  );

endmodule
